[rtl/core/wbps_pkg.sv]
`timescale 1ns / 1ps
// Package for the wildcard byte pattern scanner.
// Shared constants, status codes and register indexes; no dependencies.
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF       = 32;

    // Pattern bytes and care bits held in the config registers
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_REG_W   = 5;
    localparam int OFFSET_OUT_W = 32;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_ALLWILD = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_CARE    = 2'd2,
        REG_PAT_LEN = 2'd3
    } t_cfg_reg;

endpackage

[rtl/core/wildcard_byte_pattern_scanner.sv]
`timescale 1ns / 1ps
// A result beat is registered in the compare stage, then the output register.
// One byte per cycle while i_stall is low or no result is held; the cell chain
// compares the whole window to the masked pattern every cycle; input skid register.
// Reset (sync, active low) clears config (length goes to 1), counter, match flag and valids.
// Top level of the masked byte pattern scanner; uses wbps_pkg and wbps_cell.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_end_of_image,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_scan_status,
    output logic [OFFSET_OUT_W-1:0] o_match_offset,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // config
    logic [CFG_DATA_W-1:0] r_pat_lo, r_pat_hi;
    logic [PAT_BYTES-1:0]  r_care;
    logic [LEN_REG_W-1:0]  r_len;

    // skid
    logic       r_skid_valid, n_skid_valid;
    logic [7:0] r_skid_byte;
    logic       r_skid_last;

    // counter and compare stage
    logic [OFFSET_BITS-1:0] r_cnt, n_cnt;
    logic                   r_s1_valid;
    logic [OFFSET_BITS-1:0] r_s1_seen;
    logic                   r_s1_last;
    logic                   r_matched, n_matched;

    // output register
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [OFFSET_OUT_W-1:0] r_out_offset, n_out_offset;

    logic                   w_adv, w_in_acc, w_src_valid, w_take;
    logic [7:0]             w_src_byte;
    logic                   w_src_last;
    logic [OFFSET_BITS-1:0] w_seen_inc;
    logic [LW-1:0]          w_len;
    logic                   w_any_care, w_gate, w_all_hit, w_found, w_long_enough;
    logic [PAT_BYTES*8-1:0] w_pat;
    logic [7:0]             w_chain [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] w_hit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= LEN_REG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PAT_LO:  r_pat_lo <= i_cfg_data;
                REG_PAT_HI:  r_pat_hi <= i_cfg_data;
                REG_CARE:    r_care   <= i_cfg_data[PAT_BYTES-1:0];
                REG_PAT_LEN: r_len    <= i_cfg_data[LEN_REG_W-1:0];
            endcase
        end
    end

    assign w_pat = {r_pat_hi, r_pat_lo};
    assign w_len = (int'(r_len) > MAX_PATTERN_BYTES) ? LW'(MAX_PATTERN_BYTES) : LW'(r_len);

    always_comb begin
        w_any_care = 1'b0;
        for (int k = 0; k < PAT_BYTES; k++) begin
            if (int'(w_len) > k && r_care[k]) begin
                w_any_care = 1'b1;
            end
        end
    end

    // flow control
    assign w_adv       = !r_out_valid || !i_stall;
    assign o_stall     = r_skid_valid;
    assign w_in_acc    = i_valid && !r_skid_valid;
    assign w_src_valid = r_skid_valid || i_valid;
    assign w_src_byte  = r_skid_valid ? r_skid_byte : i_data_byte;
    assign w_src_last  = r_skid_valid ? r_skid_last : i_end_of_image;
    assign w_take      = w_src_valid && w_adv;

    always_comb begin
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (w_adv) begin
                n_skid_valid = 1'b0;
            end
        end else if (w_in_acc && !w_adv) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && w_in_acc && !w_adv) begin
            r_skid_byte <= i_data_byte;
            r_skid_last <= i_end_of_image;
        end
    end

    assign w_seen_inc = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + OFFSET_BITS'(1);

    always_comb begin
        n_cnt = r_cnt;
        if (w_take) begin
            n_cnt = w_src_last ? '0 : w_seen_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_seen <= w_seen_inc;
            r_s1_last <= w_src_last;
        end
    end

    // window cells, newest byte in cell 0
    assign w_chain[0] = w_src_byte;

    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
        wbps_cell #(
            .CELL_IDX (j),
            .LEN_BITS (LW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_shift(w_take),
            .i_byte (w_chain[j]),
            .i_pat  (w_pat),
            .i_care (r_care),
            .i_len  (w_len),
            .o_byte (w_chain[j+1]),
            .o_hit  (w_hit[j])
        );
    end

    assign w_all_hit     = &w_hit;
    assign w_long_enough = r_s1_seen >= OFFSET_BITS'(w_len);
    assign w_gate        = !r_matched && (w_len != '0) && w_any_care && w_long_enough;
    assign w_found       = w_gate && w_all_hit;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_offset = r_out_offset;
        n_matched    = r_matched;
        if (w_adv) begin
            n_out_valid = 1'b0;
            if (r_s1_valid) begin
                if (w_found) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_MATCH;
                    n_out_offset = OFFSET_OUT_W'(r_s1_seen - OFFSET_BITS'(w_len));
                end else if (r_s1_last && !r_matched) begin
                    n_out_valid  = 1'b1;
                    n_out_offset = '0;
                    if ((w_len != '0) && w_long_enough && !w_any_care) begin
                        n_out_status = ST_ALLWILD;
                    end else begin
                        n_out_status = ST_NOMATCH;
                    end
                end
                n_matched = r_s1_last ? 1'b0 : (r_matched || w_found);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_cnt        <= '0;
            r_s1_valid   <= 1'b0;
            r_matched    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_skid_valid <= n_skid_valid;
            r_cnt        <= n_cnt;
            if (w_adv) begin
                r_s1_valid <= w_take;
            end
            r_matched    <= n_matched;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_offset <= n_out_offset;
    end

    assign o_valid        = r_out_valid;
    assign o_scan_status  = r_out_status;
    assign o_match_offset = r_out_offset;

endmodule

[rtl/core/wbps_cell.sv]
`timescale 1ns / 1ps
// One window cell: holds one image byte, passes it on, and checks it
// against the pattern position it lines up with. Uses wbps_pkg.
module wbps_cell import wbps_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter int LEN_BITS = 5
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [7:0]             i_byte,
    input  logic [PAT_BYTES*8-1:0] i_pat,
    input  logic [PAT_BYTES-1:0]   i_care,
    input  logic [LEN_BITS-1:0]    i_len,
    output logic [7:0]             o_byte,
    output logic                   o_hit
);

    localparam int KW = (LEN_BITS > LEN_REG_W) ? LEN_BITS : LEN_REG_W;

    logic [7:0]          r_byte;
    logic [LEN_BITS-1:0] w_k;
    logic [KW-1:0]       w_kx;
    logic                w_in_use;
    logic                w_care;
    logic [7:0]          w_pat_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // this cell lines up with pattern position len-1-CELL_IDX
    assign w_in_use   = int'(i_len) > CELL_IDX;
    assign w_k        = i_len - LEN_BITS'(CELL_IDX + 1);
    assign w_kx       = KW'(w_k);
    assign w_care     = (w_kx < KW'(PAT_BYTES)) && i_care[w_kx[PAT_IDX_W-1:0]];
    assign w_pat_byte = i_pat[w_kx[PAT_IDX_W-1:0]*8 +: 8];

    assign o_hit  = !w_in_use || !w_care || (r_byte == w_pat_byte);
    assign o_byte = r_byte;

endmodule

[rtl/core/wbps_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the scanner, bound to the top level.
// Uses wbps_pkg for status codes.
module wbps_checker import wbps_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [1:0]              o_scan_status,
    input logic [OFFSET_OUT_W-1:0] o_match_offset
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_scan_status) && $stable(o_match_offset))
        else $error("result beat changed while stalled");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_scan_status != ST_MATCH |-> o_match_offset == '0)
        else $error("nonzero offset without a match");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid && !o_stall)
        else $error("beat pending right after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_scan_status (o_scan_status),
    .o_match_offset(o_match_offset)
);
